FILE: hdl/psg_square_noise_generator_defines.svh
// Assertion macros for the sound generator checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PSG_SQUARE_NOISE_GENERATOR_DEFINES_SVH
`define PSG_SQUARE_NOISE_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define PSG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset
`define PSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/psg_pkg.sv
`timescale 1ns / 1ps

package psg_pkg;

	localparam int BYTE_W   = 8;
	localparam int RATE_W   = 24;
	localparam int SAMPLE_W = 14;
	localparam int PERIOD_W = 10;
	localparam int ATT_W    = 4;
	localparam int CNT_W    = 11;
	localparam int LFSR_W   = 16;
	localparam int FRAC_W   = 16;
	localparam int STEPS_W  = 9;
	localparam int LEVEL_W  = 11;
	localparam int CTL_W    = 3;
	localparam int CH_W     = 2;
	localparam int NUM_TONES = 3;

	localparam logic [RATE_W-1:0] RATE_RESET         = 24'd332466;
	localparam logic [LFSR_W-1:0] LFSR_SEED          = 16'h8000;
	localparam logic [CNT_W-1:0]  ZERO_PERIOD_RELOAD = 11'h400;
	localparam logic [CNT_W-1:0]  NOISE_BASE_RELOAD  = 11'h010;
	localparam logic [ATT_W-1:0]  ATT_SILENT         = 4'hF;
	localparam logic [CH_W-1:0]   NOISE_CH           = 2'd3;
	localparam logic [1:0]        NOISE_RATE_TONE2   = 2'd3;

	// Input operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_MIX,
		ST_DONE
	} state_t;

	// Sequencer commands to the channel datapath
	typedef struct packed {
		logic            wr_en;
		logic            step_en;
		logic            mix_en;
		logic [CH_W-1:0] mix_idx;
	} ctrl_t;

	// Amplitude per attenuation code, 2 dB steps, last code silent
	function automatic logic [LEVEL_W-1:0] level_of(input logic [ATT_W-1:0] att);
		logic [LEVEL_W-1:0] lv;
		case (att)
			4'd0:    lv = 11'd2000;
			4'd1:    lv = 11'd1588;
			4'd2:    lv = 11'd1261;
			4'd3:    lv = 11'd1002;
			4'd4:    lv = 11'd796;
			4'd5:    lv = 11'd632;
			4'd6:    lv = 11'd502;
			4'd7:    lv = 11'd399;
			4'd8:    lv = 11'd316;
			4'd9:    lv = 11'd251;
			4'd10:   lv = 11'd200;
			4'd11:   lv = 11'd158;
			4'd12:   lv = 11'd126;
			4'd13:   lv = 11'd100;
			4'd14:   lv = 11'd79;
			default: lv = 11'd0;
		endcase
		return lv;
	endfunction

	// A zero period counts as the longest period
	function automatic logic [CNT_W-1:0] period_reload(input logic [PERIOD_W-1:0] p);
		logic [CNT_W-1:0] r;
		r = (p == '0) ? ZERO_PERIOD_RELOAD : CNT_W'(p);
		return r;
	endfunction

endpackage

FILE: hdl/psg_if.sv
`timescale 1ns / 1ps

// Input transactions: register byte writes and sample ticks
interface psg_req_if;
	logic                           valid;
	logic                           ready;
	logic                           operation;
	logic [psg_pkg::BYTE_W-1:0]     write_byte;
	modport source (output valid, operation, write_byte, input ready);
	modport sink (input valid, operation, write_byte, output ready);
endinterface

// Output transactions: one mixed sample per tick
interface psg_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [psg_pkg::SAMPLE_W-1:0] sample;
	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface

// Configuration writes of the step rate register
interface psg_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [psg_pkg::RATE_W-1:0] step_rate;
	modport source (output valid, step_rate, input ready);
	modport sink (input valid, step_rate, output ready);
endinterface

FILE: hdl/psg_square_noise_generator.sv
`timescale 1ns / 1ps
// Three tone, one noise sound generator with a mono output.
// req carries one transaction per register byte (operation 0) or sample
// tick (operation 1). A register byte is written when it is accepted and gives
// no output. A tick adds the 8.16 step_rate to the 16-bit phase fraction and
// runs one chip step per cycle in ST_STEP for each whole unit (5 or 6 at the
// reset rate, up to 256), then one shared adder sums the four channel levels,
// one channel per cycle in ST_MIX, into the mix register, which ST_DONE
// registers into the rsp sample; req.ready is low meanwhile.
// cfg writes step_rate at any time and is always ready; write it only while
// no tick is in flight.
// rsp holds its sample until taken. A stalled rsp holds the next tick in
// ST_DONE: register bytes and that tick are still accepted, nothing after it.
// Reset silences all channels, clears periods and counters, seeds the LFSR
// with bit 15 set and restores the default step rate.
module psg_square_noise_generator (
	input  logic       clk,
	input  logic       arst_n,
	psg_req_if.sink    req,
	psg_rsp_if.source  rsp,
	psg_cfg_if.sink    cfg
);
	import psg_pkg::*;

	ctrl_t                      ctl;
	logic [RATE_W-1:0]          step_rate_q;
	logic signed [SAMPLE_W-1:0] mix;

	// Step rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_rate_q <= RATE_RESET;
		end else if (cfg.valid) begin
			step_rate_q <= cfg.step_rate;
		end
	end

	assign cfg.ready = 1'b1;

	psg_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_operation (req.operation),
		.req_ready     (req.ready),
		.step_rate     (step_rate_q),
		.ctl           (ctl),
		.mix           (mix),
		.rsp_valid     (rsp.valid),
		.rsp_sample    (rsp.sample),
		.rsp_ready     (rsp.ready)
	);

	psg_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.wr_byte (req.write_byte),
		.mix     (mix)
	);

endmodule

FILE: hdl/psg_core.sv
`timescale 1ns / 1ps

module psg_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  psg_pkg::ctrl_t                      ctl,
	input  logic [psg_pkg::BYTE_W-1:0]          wr_byte,
	output logic signed [psg_pkg::SAMPLE_W-1:0] mix
);
	import psg_pkg::*;

	logic [CH_W-1:0]     chan_q;
	logic                vol_q;
	logic [PERIOD_W-1:0] tone_period_q [NUM_TONES];
	logic [ATT_W-1:0]    tone_att_q    [NUM_TONES];
	logic [CNT_W-1:0]    tone_cnt_q    [NUM_TONES];
	logic                tone_pol_q    [NUM_TONES];
	logic [CTL_W-1:0]    noise_ctl_q;
	logic [ATT_W-1:0]    noise_att_q;
	logic [CNT_W-1:0]    noise_cnt_q;
	logic                noise_pol_q;
	logic [LFSR_W-1:0]   lfsr_q;
	logic signed [SAMPLE_W-1:0] mix_q;

	logic [CNT_W-1:0]  tone_cnt_n [NUM_TONES];
	logic              tone_pol_n [NUM_TONES];
	logic [CNT_W-1:0]  noise_dec;
	logic [CNT_W-1:0]  noise_cnt_n;
	logic              noise_pol_n;
	logic [LFSR_W-1:0] lfsr_n;
	logic              noise_fb;

	logic [ATT_W-1:0]           mix_att;
	logic                       mix_pos;
	logic signed [SAMPLE_W-1:0] mix_mag;
	logic signed [SAMPLE_W-1:0] mix_term;
	logic signed [SAMPLE_W-1:0] mix_base;

	// One chip step: count down, reload and toggle every channel
	always_comb begin
		logic [CNT_W-1:0] dec;
		for (int i = 0; i < NUM_TONES; i++) begin
			dec = (tone_cnt_q[i] == '0) ? '0 : tone_cnt_q[i] - 1'b1;
			if (dec == '0) begin
				tone_cnt_n[i] = period_reload(tone_period_q[i]);
				tone_pol_n[i] = !tone_pol_q[i];
			end else begin
				tone_cnt_n[i] = dec;
				tone_pol_n[i] = tone_pol_q[i];
			end
		end
		noise_dec   = (noise_cnt_q == '0) ? '0 : noise_cnt_q - 1'b1;
		noise_cnt_n = noise_dec;
		noise_pol_n = noise_pol_q;
		lfsr_n      = lfsr_q;
		noise_fb    = lfsr_q[0] ^ (noise_ctl_q[2] & lfsr_q[3]);
		if (noise_dec == '0) begin
			if (noise_ctl_q[1:0] == NOISE_RATE_TONE2) begin
				noise_cnt_n = period_reload(tone_period_q[2]);
			end else begin
				noise_cnt_n = NOISE_BASE_RELOAD << noise_ctl_q[1:0];
			end
			noise_pol_n = !noise_pol_q;
			// shift only on the rising toggle
			if (!noise_pol_q) begin
				lfsr_n = {noise_fb, lfsr_q[LFSR_W-1:1]};
			end
		end
	end

	// Register writes and chip steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q      <= '0;
			vol_q       <= 1'b0;
			noise_ctl_q <= '0;
			noise_att_q <= ATT_SILENT;
			noise_cnt_q <= '0;
			noise_pol_q <= 1'b1;
			lfsr_q      <= LFSR_SEED;
			for (int i = 0; i < NUM_TONES; i++) begin
				tone_period_q[i] <= '0;
				tone_att_q[i]    <= ATT_SILENT;
				tone_cnt_q[i]    <= '0;
				tone_pol_q[i]    <= 1'b1;
			end
		end else if (ctl.wr_en) begin
			if (wr_byte[7]) begin
				// latch byte: channel, type and low four bits
				chan_q <= wr_byte[6:5];
				vol_q  <= wr_byte[4];
				if (wr_byte[4]) begin
					if (wr_byte[6:5] == NOISE_CH) begin
						noise_att_q <= wr_byte[3:0];
					end else begin
						tone_att_q[wr_byte[6:5]] <= wr_byte[3:0];
					end
				end else if (wr_byte[6:5] != NOISE_CH) begin
					tone_period_q[wr_byte[6:5]][3:0] <= wr_byte[3:0];
				end else begin
					noise_ctl_q <= wr_byte[CTL_W-1:0];
					lfsr_q      <= LFSR_SEED;
				end
			end else begin
				// data byte: upper period bits or attenuation
				if (!vol_q && chan_q != NOISE_CH) begin
					tone_period_q[chan_q][PERIOD_W-1:4] <= wr_byte[5:0];
				end else if (vol_q) begin
					if (chan_q == NOISE_CH) begin
						noise_att_q <= wr_byte[3:0];
					end else begin
						tone_att_q[chan_q] <= wr_byte[3:0];
					end
				end
			end
		end else if (ctl.step_en) begin
			for (int i = 0; i < NUM_TONES; i++) begin
				tone_cnt_q[i] <= tone_cnt_n[i];
				tone_pol_q[i] <= tone_pol_n[i];
			end
			noise_cnt_q <= noise_cnt_n;
			noise_pol_q <= noise_pol_n;
			lfsr_q      <= lfsr_n;
		end
	end

	// Select one channel's signed level for the shared adder
	always_comb begin
		if (ctl.mix_idx == NOISE_CH) begin
			mix_att = noise_att_q;
			mix_pos = lfsr_q[0];
		end else begin
			mix_att = tone_att_q[ctl.mix_idx];
			mix_pos = tone_pol_q[ctl.mix_idx];
		end
		mix_mag  = SAMPLE_W'(level_of(mix_att));
		mix_term = mix_pos ? mix_mag : -mix_mag;
		mix_base = (ctl.mix_idx == '0) ? '0 : mix_q;
	end

	// Accumulate one channel per cycle
	always_ff @(posedge clk) begin
		if (ctl.mix_en) begin
			mix_q <= mix_base + mix_term;
		end
	end

	assign mix = mix_q;

endmodule

FILE: hdl/psg_ctrl.sv
`timescale 1ns / 1ps

module psg_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_operation,
	output logic                                req_ready,
	input  logic [psg_pkg::RATE_W-1:0]          step_rate,
	output psg_pkg::ctrl_t                      ctl,
	input  logic signed [psg_pkg::SAMPLE_W-1:0] mix,
	output logic                                rsp_valid,
	output logic signed [psg_pkg::SAMPLE_W-1:0] rsp_sample,
	input  logic                                rsp_ready
);
	import psg_pkg::*;

	localparam int ACC_W = RATE_W + 1;

	state_t               state_q, state_n;
	logic [STEPS_W-1:0]   steps_q;
	logic [FRAC_W-1:0]    frac_q;
	logic [CH_W-1:0]      idx_q;
	logic                 rsp_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic [ACC_W-1:0] acc_sum;
	logic             tick_load;
	logic             out_load;

	assign acc_sum = ACC_W'(frac_q) + ACC_W'(step_rate);

	// Next state and datapath commands
	always_comb begin
		state_n     = state_q;
		req_ready   = 1'b0;
		tick_load   = 1'b0;
		out_load    = 1'b0;
		ctl.wr_en   = 1'b0;
		ctl.step_en = 1'b0;
		ctl.mix_en  = 1'b0;
		ctl.mix_idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_operation == OP_WRITE) begin
						ctl.wr_en = 1'b1;
					end else begin
						tick_load = 1'b1;
						state_n   = ST_STEP;
					end
				end
			end
			ST_STEP: begin
				if (steps_q == '0) begin
					state_n = ST_MIX;
				end else begin
					ctl.step_en = 1'b1;
				end
			end
			ST_MIX: begin
				ctl.mix_en = 1'b1;
				if (idx_q == NOISE_CH) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					out_load = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// State register and step/mix counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			steps_q     <= '0;
			frac_q      <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (tick_load) begin
				frac_q  <= acc_sum[FRAC_W-1:0];
				steps_q <= acc_sum[ACC_W-1:FRAC_W];
				idx_q   <= '0;
			end else begin
				if (ctl.step_en) begin
					steps_q <= steps_q - 1'b1;
				end
				if (ctl.mix_en) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the finished sample until taken
	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_q <= mix;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign rsp_sample = sample_q;

endmodule

FILE: hdl/psg_chk.sv
`timescale 1ns / 1ps
`include "psg_square_noise_generator_defines.svh"

module psg_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                req_operation,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic signed [psg_pkg::SAMPLE_W-1:0] rsp_sample
);

	// A tick keeps the block busy on the following cycle
	`PSG_ASSERT_NEXT(a_tick_busy, req_valid && req_ready && req_operation, !req_ready, "req ready right after a tick")

	// A register byte never blocks the next transaction
	`PSG_ASSERT_NEXT(a_write_ready, req_valid && req_ready && !req_operation, req_ready, "req not ready after a register byte")

	// A stalled sample holds
	`PSG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample), "rsp sample dropped or changed while stalled")

	// The mix of four levels stays within range
	`PSG_ASSERT_NOW(a_rsp_range, rsp_valid, $signed(rsp_sample) >= -14'sd8000 && $signed(rsp_sample) <= 14'sd8000, "rsp sample out of range")

endmodule

bind psg_square_noise_generator psg_chk u_psg_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_operation (req.operation),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_sample    (rsp.sample)
);
